// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the RTL of the reply parser.
// Needs clk and rst_n in the scope of the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPLIES(label, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error(msg);
`define ASSERT_NEXT(label, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);
`else
`define ASSERT_IMPLIES(label, cond, expr, msg)
`define ASSERT_NEXT(label, cond, expr, msg)
`endif
`endif

// ===== hdl/hmrp_pkg.sv =====
// Constants, codes and character helpers for the hex memory reply parser.
// No dependencies; imported by hex_memory_reply_parser_core and tb_top.
`timescale 1ns / 1ps

package hmrp_pkg;

    localparam int MAX_WORDS    = 8;
    localparam int STORE_BYTES  = 2 * MAX_WORDS;
    localparam int WORD_AW      = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
    localparam int POS_W        = 6;
    localparam int POS_MAX      = 63;
    localparam int BASE_ADDR    = 2048;
    localparam int LEN_FIXED    = 10;
    localparam int LEN_PER_WORD = 6;
    localparam int DATA_START   = 8;
    localparam int RECIP_THIRD  = 43;
    localparam int RECIP_SHIFT  = 7;
    localparam int CFG_IDX_W    = 2;

    localparam logic [7:0] CHAR_HASH  = 8'h23;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_TWO   = 8'h32;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;

    localparam logic [CFG_IDX_W-1:0] CFG_MAP_ADDRESS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WORD_COUNT  = 2'd1;

    typedef enum logic [1:0] {
        STATUS_OK         = 2'd0,
        STATUS_LENGTH_ERR = 2'd1,
        STATUS_ADDR_ERR   = 2'd2,
        STATUS_HEX_ERR    = 2'd3
    } status_t;

    // lowercase hex character of a nibble
    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] c;
        if (nib < 4'd10)
        begin
            c = CHAR_ZERO + {4'b0, nib};
        end
        else
        begin
            c = 8'h57 + {4'b0, nib};
        end
        return c;
    endfunction

    // {valid, value} of a hex character, either case
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [4:0] r;
        r = 5'b0;
        if (c inside {[8'h30:8'h39]})
        begin
            r = {1'b1, c[3:0]};
        end
        else if (c inside {[8'h61:8'h66], [8'h41:8'h46]})
        begin
            r = {1'b1, c[3:0] + 4'd9};
        end
        return r;
    endfunction

endpackage

// ===== hdl/hex_memory_reply_parser_core.sv =====
// Top level of the hex memory reply parser: byte capture, checks and result issue.
// Depends on hmrp_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Usage:
// Input channel (in_valid/in_stall) carries one reply character per
// transaction, with end_of_message on the final character. Each character
// is captured in the cycle it is accepted; one character per cycle is taken
// while no results are pending.
// When the final character is accepted, the checks are made in that same
// cycle and a result burst starts: one result for an error, or word_count
// results on success. gen_active_reg is set at the accepting edge and the
// first result is then loaded into the output register; after that, one
// result per cycle comes from the word-issue counter while out_stall is low.
// in_stall is high while the burst (1 to MAX_WORDS results) is being issued.
// A stall on out_stall holds a valid output register and the burst counter.
// Configuration (cfg_valid/cfg_ready, cfg_index, cfg_data) is always ready;
// index 0 writes map_address, index 1 writes word_count, others are dropped.
// Reset clears capture state, the burst and the output valid; map_address
// resets to 0 and word_count to MAX_WORDS.
module hex_memory_reply_parser_core
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [7:0]                     rx_byte,
    input  logic                           end_of_message,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic signed [15:0]             word_value,
    output logic [2:0]                     word_index,
    output logic [1:0]                     status,
    output logic                           last_result,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [hmrp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]                     cfg_data
);
    import hmrp_pkg::*;

    logic [7:0]         map_address_reg;
    logic [3:0]         word_count_reg;
    logic [POS_W-1:0]   pos_reg;
    logic [POS_W-1:0]   pos_next;
    logic               addr_match_reg;
    logic               addr_match_next;
    logic               hex_fault_reg;
    logic               hex_fault_next;
    logic               text_ended_reg;
    logic               text_ended_next;
    logic [15:0]        byte_store_reg [MAX_WORDS];

    logic               gen_active_reg;
    logic [WORD_AW-1:0] gen_idx_reg;
    logic [WORD_AW-1:0] gen_last_reg;
    status_t            gen_status_reg;

    logic               out_valid_reg;
    logic signed [15:0] word_value_reg;
    logic [2:0]         word_index_reg;
    status_t            status_reg;
    logic               last_reg;

    logic               in_accept;
    logic               eom_accept;
    logic               cap_en;
    logic [7:0]         cap_char;
    logic [POS_W-1:0]   cap_pos;
    logic [15:0]        addr_word;
    logic [7:0]         exp_char;
    logic [POS_W-1:0]   q;
    logic [11:0]        q_prod;
    logic [4:0]         slot;
    logic [6:0]         three_slot;
    logic [1:0]         digit;
    logic [4:0]         hex_dec;
    logic [3:0]         nib_we;
    logic [15:0]        nib_wdata;
    logic [WORD_AW-1:0] word_waddr;
    logic [6:0]         exp_len;
    logic               len_ok;
    status_t            msg_status;
    logic               out_load;
    logic               gen_at_last;

    assign in_accept  = in_valid && !gen_active_reg;
    assign eom_accept = in_accept && end_of_message;
    assign in_stall   = gen_active_reg;
    assign cfg_ready  = 1'b1;

    assign addr_word  = 16'(BASE_ADDR) + {7'b0, map_address_reg, 1'b0};
    assign q          = cap_pos - POS_W'(DATA_START);
    assign q_prod     = 12'(q) * 12'(RECIP_THIRD);
    assign slot       = 5'(q_prod >> RECIP_SHIFT);
    assign three_slot = 7'(slot) * 7'd3;
    assign digit      = 2'(7'(q) - three_slot);
    assign hex_dec    = hex_decode(cap_char);
    assign word_waddr = slot[WORD_AW:1];

    always_comb
    begin
        case (cap_pos)
            6'd1:    exp_char = CHAR_TWO;
            6'd2:    exp_char = CHAR_ZERO;
            6'd3:    exp_char = hex_char(addr_word[15:12]);
            6'd4:    exp_char = hex_char(addr_word[11:8]);
            6'd5:    exp_char = hex_char(addr_word[7:4]);
            6'd6:    exp_char = hex_char(addr_word[3:0]);
            default: exp_char = CHAR_NUL;
        endcase
    end

    always_comb
    begin
        pos_next        = pos_reg;
        addr_match_next = addr_match_reg;
        hex_fault_next  = hex_fault_reg;
        text_ended_next = text_ended_reg;
        cap_en          = 1'b0;
        cap_char        = rx_byte;
        cap_pos         = pos_reg;
        nib_we          = 4'b0;
        nib_wdata       = {4{hex_dec[3:0]}};

        if (in_accept && !text_ended_reg)
        begin
            if (rx_byte == CHAR_HASH)
            begin
                cap_pos         = '0;
                addr_match_next = 1'b1;
                hex_fault_next  = 1'b0;
                cap_en          = 1'b1;
            end
            else if (rx_byte == CHAR_NUL)
            begin
                if (pos_reg == '0)
                begin
                    cap_char = CHAR_SPACE;
                    cap_en   = 1'b1;
                end
                else
                begin
                    text_ended_next = 1'b1;
                end
            end
            else
            begin
                cap_en = 1'b1;
            end
        end

        if (cap_en && cap_pos < POS_W'(POS_MAX))
        begin
            if (cap_pos inside {[6'd1:6'd6]} && cap_char != exp_char)
            begin
                addr_match_next = 1'b0;
            end
            if (cap_pos >= POS_W'(DATA_START) && slot < 5'(STORE_BYTES) && digit < 2'd2)
            begin
                if (!hex_dec[4])
                begin
                    if (slot < {word_count_reg, 1'b0})
                    begin
                        hex_fault_next = 1'b1;
                    end
                end
                else if (digit == 2'd0)
                begin
                    nib_we[{slot[0], 1'b1}] = 1'b1;
                    nib_we[{slot[0], 1'b0}] = 1'b1;
                    nib_wdata               = {2{hex_dec[3:0], 4'h0}};
                end
                else
                begin
                    nib_we[{slot[0], 1'b0}] = 1'b1;
                end
            end
            pos_next = cap_pos + POS_W'(1);
        end

        exp_len = 7'(LEN_FIXED) + 7'(word_count_reg) * 7'(LEN_PER_WORD);
        len_ok  = (word_count_reg != 4'd0) && (word_count_reg <= 4'(MAX_WORDS))
                  && ({1'b0, pos_next} == exp_len);
        if (!len_ok)
        begin
            msg_status = STATUS_LENGTH_ERR;
        end
        else if (!addr_match_next)
        begin
            msg_status = STATUS_ADDR_ERR;
        end
        else if (hex_fault_next)
        begin
            msg_status = STATUS_HEX_ERR;
        end
        else
        begin
            msg_status = STATUS_OK;
        end

        if (eom_accept)
        begin
            pos_next        = '0;
            addr_match_next = 1'b1;
            hex_fault_next  = 1'b0;
            text_ended_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int n = 0; n < 4; n++)
        begin
            if (nib_we[n])
            begin
                byte_store_reg[word_waddr][4*n +: 4] <= nib_wdata[4*n +: 4];
            end
        end
    end

    assign out_load    = gen_active_reg && (!out_valid_reg || !out_stall);
    assign gen_at_last = (gen_idx_reg == gen_last_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_address_reg <= 8'd0;
            word_count_reg  <= 4'(MAX_WORDS);
            pos_reg         <= '0;
            addr_match_reg  <= 1'b1;
            hex_fault_reg   <= 1'b0;
            text_ended_reg  <= 1'b0;
            gen_active_reg  <= 1'b0;
            gen_idx_reg     <= '0;
            gen_last_reg    <= '0;
            gen_status_reg  <= STATUS_OK;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_index == CFG_MAP_ADDRESS)
            begin
                map_address_reg <= cfg_data;
            end
            if (cfg_valid && cfg_index == CFG_WORD_COUNT)
            begin
                word_count_reg <= cfg_data[3:0];
            end

            pos_reg        <= pos_next;
            addr_match_reg <= addr_match_next;
            hex_fault_reg  <= hex_fault_next;
            text_ended_reg <= text_ended_next;

            if (eom_accept)
            begin
                gen_active_reg <= 1'b1;
                gen_idx_reg    <= '0;
                gen_status_reg <= msg_status;
                if (msg_status == STATUS_OK)
                begin
                    gen_last_reg <= WORD_AW'(word_count_reg - 4'd1);
                end
                else
                begin
                    gen_last_reg <= '0;
                end
            end
            else if (out_load)
            begin
                gen_idx_reg <= gen_idx_reg + WORD_AW'(1);
                if (gen_at_last)
                begin
                    gen_active_reg <= 1'b0;
                end
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            status_reg <= gen_status_reg;
            last_reg   <= gen_at_last;
            if (gen_status_reg == STATUS_OK)
            begin
                word_value_reg <= byte_store_reg[gen_idx_reg];
                word_index_reg <= 3'(gen_idx_reg);
            end
            else
            begin
                word_value_reg <= '0;
                word_index_reg <= '0;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign word_value  = word_value_reg;
    assign word_index  = word_index_reg;
    assign status      = status_reg;
    assign last_result = last_reg;

    `ASSERT_NEXT(a_eom_starts_burst, eom_accept, gen_active_reg, "burst not started after end of message")
    `ASSERT_IMPLIES(a_idx_in_burst, gen_active_reg, gen_idx_reg <= gen_last_reg, "burst index past last")
    `ASSERT_IMPLIES(a_error_is_last, out_valid_reg && status_reg != STATUS_OK, last_reg, "error result not last")
    `ASSERT_IMPLIES(a_error_zero, out_valid_reg && status_reg != STATUS_OK, word_value_reg == 16'sd0, "error result carries data")

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking bench for hex_memory_reply_parser_core: reply text in, decoded words out.
// Depends on hmrp_pkg and the core RTL; a scoreboard class predicts and checks each word.

module tb_top;
    import hmrp_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;
    localparam logic [7:0] CHAR_NINE = 8'h39;
    localparam logic [7:0] CHAR_LO_A = 8'h61;
    localparam logic [7:0] CHAR_LO_F = 8'h66;
    localparam logic [7:0] CHAR_UP_A = 8'h41;
    localparam logic [7:0] CHAR_UP_F = 8'h46;
    localparam int RANDOM_CHARS   = 230;
    localparam int DRAIN_CYCLES   = 16;
    localparam int LONG_HOLD      = 600;
    localparam int MAX_REPORTS    = 40;

    typedef struct packed {
        logic signed [15:0] value;
        logic [2:0]         index;
        status_t            code;
        logic               last;
    } word_result_t;

    typedef enum int {
        STALL_NONE,
        STALL_COIN,
        STALL_PATTERN,
        STALL_HEAVY
    } stall_mode_t;

    typedef enum int {
        FAULT_ADDRESS,
        FAULT_BAD_HEX,
        FAULT_OVERWRITE,
        FAULT_INSERT,
        FAULT_DELETE,
        FAULT_LONG,
        FAULT_RESTART
    } fault_kind_t;

    typedef enum int {
        DIGITS_LOWER,
        DIGITS_UPPER,
        DIGITS_MIXED
    } digit_case_t;

    class reply_scoreboard;
        logic [7:0]   map_addr;
        logic [3:0]   word_cnt;
        int unsigned  text_pos;
        logic [7:0]   data_bytes [STORE_BYTES];
        bit           addr_ok;
        bit           hex_bad;
        bit           text_done;
        word_result_t pending [$];
        int           errors;
        int           words_seen;

        function new();
            map_addr = 8'd0;
            word_cnt = 4'(MAX_WORDS);
            foreach (data_bytes[i])
            begin
                data_bytes[i] = 8'd0;
            end
            errors = 0;
            words_seen = 0;
            clear_message();
        endfunction

        function void clear_message();
            text_pos = 0;
            addr_ok = 1'b1;
            hex_bad = 1'b0;
            text_done = 1'b0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] data);
            if (idx == CFG_MAP_ADDRESS)
            begin
                map_addr = data;
            end
            else if (idx == CFG_WORD_COUNT)
            begin
                word_cnt = data[3:0];
            end
        endfunction

        function int nibble(logic [7:0] c);
            if (c >= CHAR_ZERO && c <= CHAR_NINE)
            begin
                return int'(c - CHAR_ZERO);
            end
            if (c >= CHAR_LO_A && c <= CHAR_LO_F)
            begin
                return int'(c - CHAR_LO_A) + 10;
            end
            if (c >= CHAR_UP_A && c <= CHAR_UP_F)
            begin
                return int'(c - CHAR_UP_A) + 10;
            end
            return -1;
        endfunction

        function logic [7:0] hex_digit(logic [3:0] n, bit upper);
            if (n < 4'd10)
            begin
                return CHAR_ZERO + 8'(n);
            end
            return (upper ? CHAR_UP_A : CHAR_LO_A) + 8'(n) - 8'd10;
        endfunction

        function logic [7:0] addr_char(int unsigned p);
            logic [11:0] v;
            v = 12'(BASE_ADDR) + {3'b000, map_addr, 1'b0};
            if (p == 1)
            begin
                return CHAR_TWO;
            end
            if (p == 2)
            begin
                return CHAR_ZERO;
            end
            return hex_digit(4'(v >> (4 * (6 - p))), 1'b0);
        endfunction

        function void capture(logic [7:0] c);
            int unsigned p;
            int unsigned q;
            int unsigned slot;
            int unsigned digit;
            int h;
            p = text_pos;
            if (p >= POS_MAX)
            begin
                return;
            end
            if (p >= 1 && p <= 6 && c != addr_char(p))
            begin
                addr_ok = 1'b0;
            end
            if (p >= DATA_START)
            begin
                q = p - DATA_START;
                slot = q / 3;
                digit = q % 3;
                if (digit < 2 && slot < STORE_BYTES)
                begin
                    h = nibble(c);
                    if (h < 0)
                    begin
                        if (slot < 2 * word_cnt)
                        begin
                            hex_bad = 1'b1;
                        end
                    end
                    else if (digit == 0)
                    begin
                        data_bytes[slot] = {4'(h), 4'h0};
                    end
                    else
                    begin
                        data_bytes[slot][3:0] = 4'(h);
                    end
                end
            end
            text_pos = p + 1;
        endfunction

        // returns 0 when the character is dropped after the end of the text
        function bit note_char(logic [7:0] c, bit eom);
            int unsigned  wc;
            status_t      code;
            word_result_t r;
            bit           used;
            wc = word_cnt;
            used = !text_done;
            if (!text_done)
            begin
                if (c == CHAR_HASH)
                begin
                    text_pos = 0;
                    addr_ok = 1'b1;
                    hex_bad = 1'b0;
                    capture(c);
                end
                else if (c == CHAR_NUL)
                begin
                    if (text_pos == 0)
                    begin
                        capture(CHAR_SPACE);
                    end
                    else
                    begin
                        text_done = 1'b1;
                    end
                end
                else
                begin
                    capture(c);
                end
            end
            if (!eom)
            begin
                return used;
            end
            if (wc == 0 || wc > MAX_WORDS || text_pos != LEN_FIXED + LEN_PER_WORD * wc)
            begin
                code = STATUS_LENGTH_ERR;
            end
            else if (!addr_ok)
            begin
                code = STATUS_ADDR_ERR;
            end
            else if (hex_bad)
            begin
                code = STATUS_HEX_ERR;
            end
            else
            begin
                code = STATUS_OK;
            end
            clear_message();
            if (code != STATUS_OK)
            begin
                r.value = 16'sd0;
                r.index = 3'd0;
                r.code = code;
                r.last = 1'b1;
                pending.push_back(r);
            end
            else
            begin
                for (int k = 0; k < wc; k++)
                begin
                    r.value = {data_bytes[2 * k + 1], data_bytes[2 * k]};
                    r.index = 3'(k);
                    r.code = STATUS_OK;
                    r.last = (k + 1 == wc);
                    pending.push_back(r);
                end
            end
            return 1'b1;
        endfunction

        function void report(string what);
            errors++;
            if (errors <= MAX_REPORTS)
            begin
                $display("mismatch at %0t: %s", $time, what);
            end
        endfunction

        function void check_word(logic signed [15:0] value, logic [2:0] index,
                                 logic [1:0] code, logic last);
            word_result_t want;
            words_seen++;
            if (pending.size() == 0)
            begin
                report($sformatf("unexpected word value %0d index %0d status %0d",
                                 value, index, code));
                return;
            end
            want = pending.pop_front();
            if (value !== want.value)
            begin
                report($sformatf("word_value %0d, expected %0d", value, want.value));
            end
            if (index !== want.index)
            begin
                report($sformatf("word_index %0d, expected %0d", index, want.index));
            end
            if (code !== want.code)
            begin
                report($sformatf("status %0d, expected %0d", code, want.code));
            end
            if (last !== want.last)
            begin
                report($sformatf("last_result %0b, expected %0b", last, want.last));
            end
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic [7:0]           rx_byte = 8'd0;
    logic                 end_of_message = 1'b0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic signed [15:0]   word_value;
    logic [2:0]           word_index;
    logic [1:0]           status;
    logic                 last_result;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_MAP_ADDRESS;
    logic [7:0]           cfg_data = 8'd0;

    reply_scoreboard sb;
    logic [7:0]      reply [$];
    int              burst_left = 0;
    int              chars_taken = 0;
    bit              hold_req = 1'b0;

    hex_memory_reply_parser_core dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .rx_byte        (rx_byte),
        .end_of_message (end_of_message),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .word_value     (word_value),
        .word_index     (word_index),
        .status         (status),
        .last_result    (last_result),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    initial
    begin
        #3_000_000;
        $display("FAIL");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            sb.check_word(word_value, word_index, status, last_result);
        end
    end

    initial
    begin : receiver
        int          hold_left;
        int          seg_left;
        int          tick;
        stall_mode_t mode;
        hold_left = 0;
        seg_left = 0;
        tick = 0;
        mode = STALL_NONE;
        forever
        begin
            @(negedge clk);
            tick++;
            if (hold_req)
            begin
                hold_left = LONG_HOLD;
                hold_req = 1'b0;
            end
            if (seg_left == 0)
            begin
                mode = stall_mode_t'($urandom_range(0, STALL_HEAVY));
                seg_left = $urandom_range(8, 80);
            end
            seg_left--;
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                case (mode)
                    STALL_COIN:    out_stall <= ($urandom_range(0, 1) == 1);
                    STALL_PATTERN: out_stall <= ((tick % 5) < 2);
                    STALL_HEAVY:   out_stall <= ($urandom_range(0, 9) < 8);
                    default:       out_stall <= 1'b0;
                endcase
            end
        end
    end

    task automatic push_char(logic [7:0] c, bit eom);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 150)
                                                      : $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        rx_byte <= c;
        end_of_message <= eom;
        do
            @(posedge clk);
        while (in_stall);
        if (sb.note_char(c, eom))
        begin
            chars_taken++;
        end
        @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.write_reg(idx, data);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    // drop valid, then wait for every pending word plus the tail of the burst
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (sb.pending.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++)
        begin
            push_char(s[i], i == s.len() - 1);
        end
    endtask

    task automatic send_reply();
        for (int i = 0; i < reply.size(); i++)
        begin
            push_char(reply[i], i == reply.size() - 1);
        end
    endtask

    function automatic logic [7:0] plain_char();
        logic [7:0] c;
        do
            c = 8'($urandom_range(1, 255));
        while (c == CHAR_HASH);
        return c;
    endfunction

    function automatic logic [7:0] filler_char();
        return ($urandom_range(0, 3) == 0) ? plain_char() : CHAR_SPACE;
    endfunction

    task automatic push_hex_byte(logic [7:0] b, digit_case_t dc);
        bit up_hi;
        bit up_lo;
        up_hi = (dc == DIGITS_UPPER) || (dc == DIGITS_MIXED && $urandom_range(0, 1) == 1);
        up_lo = (dc == DIGITS_UPPER) || (dc == DIGITS_MIXED && $urandom_range(0, 1) == 1);
        reply.push_back(sb.hex_digit(b[7:4], up_hi));
        reply.push_back(sb.hex_digit(b[3:0], up_lo));
    endtask

    task automatic build_reply();
        int          words;
        int          origin;
        int          idx;
        int          off;
        logic [15:0] w;
        logic [7:0]  c;
        digit_case_t dc;
        fault_kind_t fault;
        reply.delete();
        words = (sb.word_cnt >= 1 && sb.word_cnt <= MAX_WORDS) ? int'(sb.word_cnt)
                                                                : $urandom_range(1, MAX_WORDS);
        dc = digit_case_t'($urandom_range(0, DIGITS_MIXED));
        origin = 0;
        case ($urandom_range(0, 7))
            0: reply.push_back(CHAR_NUL);
            1: reply.push_back(plain_char());
            default:
            begin
                if ($urandom_range(0, 4) == 0)
                begin
                    reply.push_back(CHAR_HASH);
                    reply.push_back(CHAR_TWO);
                    reply.push_back(CHAR_ZERO);
                end
                repeat ($urandom_range(0, 3)) reply.push_back(plain_char());
                origin = reply.size();
                reply.push_back(CHAR_HASH);
            end
        endcase
        for (int p = 1; p <= 6; p++)
        begin
            reply.push_back(sb.addr_char(p));
        end
        reply.push_back(filler_char());
        for (int k = 0; k < words; k++)
        begin
            case ($urandom_range(0, 7))
                0:       w = 16'h8000;
                1:       w = 16'h7fff;
                2:       w = 16'hffff;
                3:       w = 16'h0000;
                default: w = 16'($urandom);
            endcase
            push_hex_byte(w[7:0], dc);
            reply.push_back(filler_char());
            push_hex_byte(w[15:8], dc);
            reply.push_back(filler_char());
        end
        push_hex_byte(8'($urandom), dc);

        if ($urandom_range(0, 9) < 3)
        begin
            repeat ($urandom_range(1, 2))
            begin
                fault = fault_kind_t'($urandom_range(0, FAULT_RESTART));
                idx = $urandom_range(origin + 1, reply.size() - 1);
                case (fault)
                    FAULT_ADDRESS:
                    begin
                        idx = origin + $urandom_range(1, 6);
                        c = reply[idx];
                        if (c >= CHAR_LO_A && $urandom_range(0, 1) == 1)
                        begin
                            reply[idx] = c - CHAR_LO_A + CHAR_UP_A;
                        end
                        else
                        begin
                            do
                                reply[idx] = plain_char();
                            while (reply[idx] == c);
                        end
                    end
                    FAULT_BAD_HEX:
                    begin
                        off = $urandom_range(0, 3);
                        if (off >= 2)
                        begin
                            off++;
                        end
                        idx = origin + DATA_START + 6 * $urandom_range(0, words - 1) + off;
                        do
                            c = plain_char();
                        while (sb.nibble(c) >= 0);
                        reply[idx] = c;
                    end
                    FAULT_OVERWRITE: reply[idx] = 8'($urandom);
                    FAULT_INSERT:    reply.insert(idx, filler_char());
                    FAULT_DELETE:    reply.delete(idx);
                    FAULT_LONG:
                    begin
                        repeat ($urandom_range(40, 60)) reply.insert(idx, filler_char());
                    end
                    default:         reply.insert(idx, CHAR_HASH);
                endcase
            end
        end

        case ($urandom_range(0, 3))
            2: reply.push_back(CHAR_NUL);
            3:
            begin
                reply.push_back(CHAR_NUL);
                repeat ($urandom_range(1, 4)) reply.push_back(8'($urandom));
            end
            default: ;
        endcase
    endtask

    task automatic build_noise();
        reply.delete();
        repeat ($urandom_range(1, 12)) reply.push_back(8'($urandom));
    endtask

    initial
    begin
        sb = new();
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        write_reg(CFG_MAP_ADDRESS, 8'hff);
        write_reg(CFG_WORD_COUNT, 8'd1);
        write_reg(CFG_SPARE_A, 8'h5a);
        push_char(CHAR_HASH, 1'b1);
        push_char(CHAR_NUL, 1'b1);
        push_char(CHAR_NUL, 1'b0);
        send_text("2009fe aB 80 3A");
        wait_idle();

        hold_req = 1'b1;
        chars_taken = 0;
        while (chars_taken < RANDOM_CHARS)
        begin
            if ($urandom_range(0, 9) < 7)
            begin
                case ($urandom_range(0, 3))
                    0:       write_reg(CFG_MAP_ADDRESS, 8'h00);
                    1:       write_reg(CFG_MAP_ADDRESS, 8'hff);
                    default: write_reg(CFG_MAP_ADDRESS, 8'($urandom));
                endcase
            end
            case ($urandom_range(0, 9))
                0: write_reg(CFG_WORD_COUNT, 8'd1);
                1: write_reg(CFG_WORD_COUNT, 8'(MAX_WORDS));
                2: write_reg(CFG_WORD_COUNT,
                             {4'($urandom), ($urandom_range(0, 1) == 1)
                                            ? 4'd0 : 4'($urandom_range(MAX_WORDS + 1, 15))});
                3: write_reg(CFG_WORD_COUNT, {4'($urandom), 4'($urandom_range(1, MAX_WORDS))});
                default: write_reg(CFG_WORD_COUNT, 8'($urandom_range(1, MAX_WORDS)));
            endcase
            if ($urandom_range(0, 9) == 0)
            begin
                write_reg(($urandom_range(0, 1) == 1) ? CFG_SPARE_A : CFG_SPARE_B, 8'($urandom));
            end
            repeat ($urandom_range(1, 3))
            begin
                if (chars_taken < RANDOM_CHARS)
                begin
                    if ($urandom_range(0, 9) == 0)
                    begin
                        build_noise();
                    end
                    else
                    begin
                        build_reply();
                    end
                    send_reply();
                end
            end
            wait_idle();
        end

        if (sb.errors == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
